@@ hw/rtl/cons_pkg.sv @@
// Console package: field widths, op codes, register map and item structs.
// Used by the interfaces, the controller and the top level.
package cons_pkg;

  localparam int OP_W   = 3;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 16;

  localparam logic [OP_W-1:0] OP_PUT       = 3'd0;
  localparam logic [OP_W-1:0] OP_BACKSPACE = 3'd1;
  localparam logic [OP_W-1:0] OP_NEWLINE   = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE_AT  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ      = 3'd4;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

  // Register map: one 32-bit register per word
  localparam int              PADDR_W          = 3;
  localparam logic            REG_DEFAULT_ATTR = 1'b0;
  localparam logic [ATTR_W-1:0] ATTR_RESET     = 8'd15;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ATTR_W-1:0] color;
  } cons_item_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CELL_W-1:0] read_data;
    logic              scrolled;
    logic              ignored;
  } cons_res_t;

endpackage

@@ hw/rtl/cons_in_if.sv @@
// Input item channel of the console: valid/ready plus the op fields.
// Depends on cons_pkg for field widths.
interface cons_in_if import cons_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CHAR_W-1:0] char_code;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [ATTR_W-1:0] color;

  modport source (output valid, op, char_code, col, row, color, input ready);
  modport sink   (input valid, op, char_code, col, row, color, output ready);
endinterface

@@ hw/rtl/cons_out_if.sv @@
// Result item channel of the console: valid/ready plus cursor and read data.
// Depends on cons_pkg for field widths.
interface cons_out_if import cons_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [CELL_W-1:0] read_data;
  logic              scrolled;
  logic              ignored;

  modport source (output valid, cursor_col, cursor_row, read_data, scrolled, ignored,
                  input ready);
  modport sink   (input valid, cursor_col, cursor_row, read_data, scrolled, ignored,
                  output ready);
endinterface

@@ hw/rtl/text_console_cursor_scroll.sv @@
// Text-mode console: cell store, cursor, scroll sequencer and APB register.
// Depends on cons_pkg, cons_in_if, cons_out_if, cons_ctrl, cons_store, cons_addr.
//
// After reset the block clears its COLUMNS*ROWS cell store one cell a cycle
// and takes no item until that pass is done. Each item then passes through
// S_EXEC and S_DONE (an in-range read also through S_READ, which waits on the
// registered store read). A put or newline that scrolls walks the single write
// port of the store: it copies every cell below the top row up by one row,
// drains the last copy and then blanks the last row. One item is in work at a
// time; an output register holds the result so the next item can be taken
// while it waits. default_attribute is at byte address 0.
module text_console_cursor_scroll import cons_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  cons_in_if.sink            item_i,
  cons_out_if.source         result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  logic [ATTR_W-1:0] attr_q;
  logic              reg_hit;
  cons_item_t        item;
  cons_res_t         res;
  cons_res_t         res_q;
  logic              out_valid_q;
  logic              out_free;
  logic              done;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  // Register file
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_DEFAULT_ATTR);
  assign prdata  = reg_hit ? {24'b0, attr_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      attr_q <= pwdata[ATTR_W-1:0];
    end
  end

  assign item.op        = item_i.op;
  assign item.char_code = item_i.char_code;
  assign item.col       = item_i.col;
  assign item.row       = item_i.row;
  assign item.color     = item_i.color;

  cons_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .item_i      (item),
    .attr_i      (attr_q),
    .out_free_i  (out_free),
    .done_o      (done),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  cons_store #(
    .DEPTH (CELLS),
    .AW    (AW),
    .DW    (CELL_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Output register: hold the result until taken
  assign out_free = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q <= res;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.cursor_col = res_q.cursor_col;
  assign result_o.cursor_row = res_q.cursor_row;
  assign result_o.read_data  = res_q.read_data;
  assign result_o.scrolled   = res_q.scrolled;
  assign result_o.ignored    = res_q.ignored;

endmodule

@@ hw/rtl/cons_addr.sv @@
// Shared cell address unit: base + row * COLUMNS + col.
// Depends on cons_pkg for coordinate widths.
module cons_addr import cons_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int AW      = 11
) (
  input  logic [AW-1:0]    base_i,
  input  logic [ROW_W-1:0] row_i,
  input  logic [COL_W-1:0] col_i,
  output logic [AW-1:0]    addr_o
);

  localparam int SUM_W = ROW_W + COL_W + 1;

  logic [SUM_W-1:0] sum;

  assign sum = SUM_W'(base_i) + SUM_W'(row_i) * SUM_W'(COLUMNS) + SUM_W'(col_i);
  assign addr_o = sum[AW-1:0];

endmodule

@@ hw/rtl/cons_store.sv @@
// Screen cell store: one write port, one read port with registered data.
// Standalone; no package needed.
module cons_store #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11,
  parameter int DW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/cons_ctrl.sv @@
// Console sequencer: cursor state, op decode, clear and scroll sweeps.
// Depends on cons_pkg; drives the cell store through the shared cons_addr unit.
module cons_ctrl import cons_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int AW      = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cons_item_t        item_i,
  input  logic [ATTR_W-1:0] attr_i,
  input  logic              out_free_i,
  output logic              done_o,
  output cons_res_t         res_o,
  output logic              mem_we_o,
  output logic [AW-1:0]     mem_waddr_o,
  output logic [CELL_W-1:0] mem_wdata_o,
  output logic [AW-1:0]     mem_raddr_o,
  input  logic [CELL_W-1:0] mem_rdata_i
);

  localparam int CELLS = COLUMNS * ROWS;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_EXEC   = 7'b0000100,
    S_READ   = 7'b0001000,
    S_SCROLL = 7'b0010000,
    S_FILL   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [AW-1:0]     waddr_q, waddr_d;
  logic              pend_q, pend_d;
  cons_item_t        item_q, item_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [CELL_W-1:0] rdata_q, rdata_d;
  logic              scrolled_q, scrolled_d;
  logic              ignored_q, ignored_d;

  logic              is_nl;
  logic              at_last_row;
  logic [COL_W:0]    col_inc;
  logic              wrap;
  logic              in_range;
  logic [COL_W-1:0]  bs_col;
  logic [ROW_W-1:0]  bs_row;
  logic [AW-1:0]     a_base;
  logic [ROW_W-1:0]  a_row;
  logic [COL_W-1:0]  a_col;
  logic [AW-1:0]     addr;
  logic [CELL_W-1:0] blank;

  assign blank       = {attr_i, SPACE_CODE};
  assign is_nl       = (item_q.op == OP_NEWLINE) ||
                       ((item_q.op == OP_PUT) && (item_q.char_code == NEWLINE_CODE));
  assign at_last_row = (cur_row_q == ROW_W'(ROWS - 1));
  assign col_inc     = {1'b0, cur_col_q} + 1'b1;
  assign wrap        = (col_inc == (COL_W + 1)'(COLUMNS));
  assign in_range    = ({1'b0, item_q.col} < (COL_W + 1)'(COLUMNS)) &&
                       ({1'b0, item_q.row} < (ROW_W + 1)'(ROWS));

  // Backspace target: step left, or up to the end of the previous line; stays at the top left
  always_comb begin
    bs_col = cur_col_q;
    bs_row = cur_row_q;
    if (cur_col_q != '0) begin
      bs_col = cur_col_q - 1'b1;
    end else if (cur_row_q != '0) begin
      bs_row = cur_row_q - 1'b1;
      bs_col = COL_W'(COLUMNS - 1);
    end
  end

  // Operand select for the shared address unit
  always_comb begin
    a_base = '0;
    a_row  = cur_row_q;
    a_col  = cur_col_q;
    if (state_q == S_SCROLL) begin
      a_base = idx_q;
      a_row  = ROW_W'(1);
      a_col  = '0;
    end else if (state_q == S_FILL) begin
      a_base = idx_q;
      a_row  = '0;
      a_col  = '0;
    end else if (item_q.op == OP_BACKSPACE) begin
      a_row = bs_row;
      a_col = bs_col;
    end else if ((item_q.op == OP_WRITE_AT) || (item_q.op == OP_READ)) begin
      a_row = item_q.row;
      a_col = item_q.col;
    end
  end

  cons_addr #(
    .COLUMNS (COLUMNS),
    .AW      (AW)
  ) u_addr (
    .base_i (a_base),
    .row_i  (a_row),
    .col_i  (a_col),
    .addr_o (addr)
  );

  // Store port drive
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = addr;
    mem_wdata_o = blank;
    mem_raddr_o = addr;
    unique case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = '0;
      end
      S_EXEC: begin
        case (item_q.op)
          OP_PUT: begin
            mem_we_o    = !is_nl;
            mem_wdata_o = {attr_i, item_q.char_code};
          end
          OP_BACKSPACE: begin
            mem_we_o = 1'b1;
          end
          OP_WRITE_AT: begin
            mem_we_o    = in_range;
            mem_wdata_o = {item_q.color, item_q.char_code};
          end
          default: begin
            mem_we_o = 1'b0;
          end
        endcase
      end
      S_SCROLL: begin
        mem_we_o    = pend_q;
        mem_waddr_o = waddr_q;
        mem_wdata_o = mem_rdata_i;
      end
      S_FILL: begin
        mem_we_o = 1'b1;
        if (pend_q) begin
          mem_waddr_o = waddr_q;
          mem_wdata_o = mem_rdata_i;
        end
      end
      default: begin
        mem_we_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    waddr_d    = waddr_q;
    pend_d     = pend_q;
    item_d     = item_q;
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    rdata_d    = rdata_q;
    scrolled_d = scrolled_q;
    ignored_d  = ignored_q;
    unique case (state_q)
      S_CLEAR: begin
        if (idx_q == AW'(CELLS - 1)) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          item_d     = item_i;
          rdata_d    = '0;
          scrolled_d = 1'b0;
          ignored_d  = 1'b0;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (item_q.op) inside
          OP_PUT, OP_NEWLINE: begin
            if (is_nl || wrap) begin
              cur_col_d = '0;
              if (at_last_row) begin
                // Scroll: copy rows up, then blank the last row
                scrolled_d = 1'b1;
                idx_d      = '0;
                pend_d     = 1'b0;
                state_d    = S_SCROLL;
              end else begin
                cur_row_d = cur_row_q + 1'b1;
              end
            end else begin
              cur_col_d = col_inc[COL_W-1:0];
            end
          end
          OP_BACKSPACE: begin
            cur_col_d = bs_col;
            cur_row_d = bs_row;
          end
          OP_WRITE_AT: begin
            ignored_d = !in_range;
          end
          OP_READ: begin
            ignored_d = !in_range;
            if (in_range) begin
              state_d = S_READ;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_READ: begin
        rdata_d = mem_rdata_i;
        state_d = S_DONE;
      end
      S_SCROLL: begin
        // Read one row below, write back on the next cycle
        pend_d  = 1'b1;
        waddr_d = idx_q;
        idx_d   = idx_q + 1'b1;
        if (idx_q == AW'(CELLS - COLUMNS - 1)) begin
          state_d = S_FILL;
        end
      end
      S_FILL: begin
        if (pend_q) begin
          pend_d = 1'b0;
        end else if (idx_q == AW'(CELLS - 1)) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      idx_q     <= '0;
      pend_q    <= 1'b0;
      cur_col_q <= '0;
      cur_row_q <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      pend_q    <= pend_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    waddr_q    <= waddr_d;
    item_q     <= item_d;
    rdata_q    <= rdata_d;
    scrolled_q <= scrolled_d;
    ignored_q  <= ignored_d;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign done_o     = (state_q == S_DONE) && out_free_i;

  assign res_o.cursor_col = cur_col_q;
  assign res_o.cursor_row = cur_row_q;
  assign res_o.read_data  = rdata_q;
  assign res_o.scrolled   = scrolled_q;
  assign res_o.ignored    = ignored_q;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_EXEC))
    else $error("accepted item did not start execution");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_IDLE) || (state_q == S_DONE) || (state_q == S_READ)) |-> !mem_we_o)
    else $error("store written outside an active step");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_col_q} < (COL_W + 1)'(COLUMNS)) && ({1'b0, cur_row_q} < (ROW_W + 1)'(ROWS)))
    else $error("cursor left the screen");

  a_scroll_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCROLL) || (state_q == S_FILL)) |-> (at_last_row && scrolled_q))
    else $error("scroll sweep without cursor on last row");

  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result issued twice for one item");

endmodule

@@ dv/tb_text_console_cursor_scroll.sv @@
`timescale 1ns / 1ps
// Testbench for text_console_cursor_scroll: directed table, then random op mix and put bursts.
// Depends on cons_pkg, cons_in_if, cons_out_if and the console RTL.
module tb_text_console_cursor_scroll import cons_pkg::*; ();

  localparam int COLUMNS         = 80;
  localparam int ROWS            = 25;
  localparam int NUM_DIRECTED    = 23;
  localparam int NUM_PHASES      = 5;
  localparam int ITEMS_PER_PHASE = 225;

  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  localparam logic [PADDR_W-1:0] ATTR_ADDR = PADDR_W'({REG_DEFAULT_ATTR, 2'b00});

  localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0] COL_OVER = COL_W'(COLUMNS);
  localparam logic [ROW_W-1:0] ROW_OVER = ROW_W'(ROWS);
  localparam logic [COL_W-1:0] COL_MAX  = '1;
  localparam logic [ROW_W-1:0] ROW_MAX  = '1;

  typedef struct {
    cons_item_t stim;
    bit         typed;
    cons_res_t  want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cons_in_if  item_if ();
  cons_out_if result_if ();

  text_console_cursor_scroll #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the console: cell store, cursor and attribute register
  logic [CELL_W-1:0] shadow_cells [ROWS][COLUMNS];
  int                shadow_col;
  int                shadow_row;
  logic [ATTR_W-1:0] shadow_attr;

  cons_res_t awaited_results [$];
  dir_row_t  directed_rows [NUM_DIRECTED];
  int        mismatch_count = 0;
  int        max_gap   = 3;
  int        max_stall = 3;

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Move all rows up and blank the last one once the cursor has gone past the bottom line.
  function automatic logic scroll_if_past_bottom();
    if (shadow_row < ROWS) return 1'b0;
    for (int r = 0; r < ROWS - 1; r++) shadow_cells[r] = shadow_cells[r + 1];
    for (int c = 0; c < COLUMNS; c++) shadow_cells[ROWS - 1][c] = {shadow_attr, SPACE_CODE};
    shadow_row = ROWS - 1;
    return 1'b1;
  endfunction

  function automatic cons_res_t console_apply(cons_item_t it);
    cons_res_t res;
    logic      in_range;
    res      = '0;
    in_range = (int'(it.col) < COLUMNS) && (int'(it.row) < ROWS);
    case (it.op)
      OP_PUT: begin
        if (it.char_code == NEWLINE_CODE) begin
          shadow_col = 0;
          shadow_row++;
        end else begin
          shadow_cells[shadow_row][shadow_col] = {shadow_attr, it.char_code};
          shadow_col++;
          if (shadow_col >= COLUMNS) begin
            shadow_col = 0;
            shadow_row++;
          end
        end
        res.scrolled = scroll_if_past_bottom();
      end
      OP_BACKSPACE: begin
        if (shadow_col > 0) begin
          shadow_col--;
        end else if (shadow_row > 0) begin
          shadow_row--;
          shadow_col = COLUMNS - 1;
        end
        shadow_cells[shadow_row][shadow_col] = {shadow_attr, SPACE_CODE};
      end
      OP_NEWLINE: begin
        shadow_col = 0;
        shadow_row++;
        res.scrolled = scroll_if_past_bottom();
      end
      OP_WRITE_AT: begin
        if (in_range) shadow_cells[it.row][it.col] = {it.color, it.char_code};
        else res.ignored = 1'b1;
      end
      OP_READ: begin
        if (in_range) res.read_data = shadow_cells[it.row][it.col];
        else res.ignored = 1'b1;
      end
      default: ;
    endcase
    res.cursor_col = COL_W'(shadow_col);
    res.cursor_row = ROW_W'(shadow_row);
    return res;
  endfunction

  function automatic cons_item_t random_console_item();
    cons_item_t it;
    int         pick;
    it.op        = OP_PUT;
    it.char_code = CHAR_W'($urandom_range(0, 255));
    it.color     = ATTR_W'($urandom_range(0, 255));
    // mostly in range, else anywhere in the field
    if ($urandom_range(0, 99) < 85) begin
      it.col = COL_W'($urandom_range(0, COLUMNS - 1));
      it.row = ROW_W'($urandom_range(0, ROWS - 1));
    end else begin
      it.col = COL_W'($urandom_range(0, 2**COL_W - 1));
      it.row = ROW_W'($urandom_range(0, 2**ROW_W - 1));
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      it.op = OP_PUT;
      if ($urandom_range(0, 19) == 0) it.char_code = NEWLINE_CODE;
    end else if (pick < 50) begin
      it.op = OP_BACKSPACE;
    end else if (pick < 58) begin
      it.op = OP_NEWLINE;
    end else if (pick < 73) begin
      it.op = OP_WRITE_AT;
    end else if (pick < 93) begin
      it.op = OP_READ;
    end else begin
      case ($urandom_range(0, 2))
        0:       it.op = OP_SPARE_A;
        1:       it.op = OP_SPARE_B;
        default: it.op = OP_SPARE_C;
      endcase
    end
    return it;
  endfunction

  task automatic send_item(input cons_item_t it, input bit typed, input cons_res_t typed_res);
    int        gap;
    cons_res_t predicted;
    gap = $urandom_range(0, max_gap);
    @(negedge clk_i);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_if.valid     <= 1'b1;
    item_if.op        <= it.op;
    item_if.char_code <= it.char_code;
    item_if.col       <= it.col;
    item_if.row       <= it.row;
    item_if.color     <= it.color;
    do @(posedge clk_i); while (!(item_if.valid && item_if.ready));
    predicted = console_apply(it);
    awaited_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    item_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // Write the attribute with noise in the unused upper bits, then read it back.
  task automatic write_default_attr(input logic [ATTR_W-1:0] value);
    logic [31:0] noise;
    logic [31:0] readback;
    noise = $urandom;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= {noise[31:ATTR_W], value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    shadow_attr = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    readback = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[ATTR_W-1:0] !== value) begin
      $error("default_attribute: expected %0h, got %0h", value, readback[ATTR_W-1:0]);
      mismatch_count++;
    end
  endtask

  task automatic check_result(input cons_res_t got);
    cons_res_t want;
    if (awaited_results.size() == 0) begin
      $error("result item with nothing expected");
      mismatch_count++;
      return;
    end
    want = awaited_results.pop_front();
    if (got.cursor_col !== want.cursor_col) begin
      $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
      mismatch_count++;
    end
    if (got.cursor_row !== want.cursor_row) begin
      $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
      mismatch_count++;
    end
    if (got.read_data !== want.read_data) begin
      $error("read_data: expected %04h, got %04h", want.read_data, got.read_data);
      mismatch_count++;
    end
    if (got.scrolled !== want.scrolled) begin
      $error("scrolled: expected %0b, got %0b", want.scrolled, got.scrolled);
      mismatch_count++;
    end
    if (got.ignored !== want.ignored) begin
      $error("ignored: expected %0b, got %0b", want.ignored, got.ignored);
      mismatch_count++;
    end
  endtask

  initial begin : result_sink
    int        stall;
    cons_res_t got;
    result_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = $urandom_range(0, max_stall);
      @(negedge clk_i);
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(result_if.valid && result_if.ready));
      got = {result_if.cursor_col, result_if.cursor_row, result_if.read_data,
             result_if.scrolled, result_if.ignored};
      check_result(got);
    end
  end

  initial begin : stimulus
    cons_item_t it;
    int         sent;
    int         burst_len;
    logic [ATTR_W-1:0] attr;

    rst_ni            = 1'b0;
    item_if.valid     = 1'b0;
    item_if.op        = OP_PUT;
    item_if.char_code = '0;
    item_if.col       = '0;
    item_if.row       = '0;
    item_if.color     = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLUMNS; c++) shadow_cells[r][c] = '0;
    shadow_col  = 0;
    shadow_row  = 0;
    shadow_attr = ATTR_RESET;

    // Directed part at the reset attribute; typed rows need no predictor.
    directed_rows = '{
      '{{OP_READ, 8'h00, 7'd0, 5'd0, 8'h00}, 1'b1, {7'd0, 5'd0, 16'h0000, 1'b0, 1'b0}},
      '{{OP_READ, 8'h00, COL_LAST, ROW_LAST, 8'h00}, 1'b1,
        {7'd0, 5'd0, 16'h0000, 1'b0, 1'b0}},
      '{{OP_READ, 8'h00, COL_OVER, 5'd0, 8'h00}, 1'b1, {7'd0, 5'd0, 16'h0000, 1'b0, 1'b1}},
      '{{OP_READ, 8'h00, 7'd0, ROW_OVER, 8'h00}, 1'b1, {7'd0, 5'd0, 16'h0000, 1'b0, 1'b1}},
      '{{OP_WRITE_AT, 8'hFF, COL_MAX, ROW_MAX, 8'hFF}, 1'b1,
        {7'd0, 5'd0, 16'h0000, 1'b0, 1'b1}},
      // backspace at top left: cursor stays, cell gets a blank
      '{{OP_BACKSPACE, 8'h00, 7'd0, 5'd0, 8'h00}, 1'b1, {7'd0, 5'd0, 16'h0000, 1'b0, 1'b0}},
      '{{OP_READ, 8'h00, 7'd0, 5'd0, 8'h00}, 1'b1,
        {7'd0, 5'd0, {ATTR_RESET, SPACE_CODE}, 1'b0, 1'b0}},
      '{{OP_PUT, 8'h41, 7'd0, 5'd0, 8'h00}, 1'b0, '0},
      '{{OP_PUT, 8'hFF, COL_MAX, ROW_MAX, 8'hFF}, 1'b0, '0},
      '{{OP_PUT, 8'h00, 7'd0, 5'd0, 8'h00}, 1'b0, '0},
      '{{OP_PUT, NEWLINE_CODE, 7'd0, 5'd0, 8'h00}, 1'b0, '0},
      '{{OP_READ, 8'h00, 7'd3, 5'd0, 8'h00}, 1'b0, '0},
      '{{OP_NEWLINE, 8'h00, 7'd0, 5'd0, 8'h00}, 1'b0, '0},
      // backspace from column 0 wraps to the end of the previous line
      '{{OP_BACKSPACE, 8'h00, 7'd0, 5'd0, 8'h00}, 1'b0, '0},
      '{{OP_READ, 8'h00, COL_LAST, 5'd1, 8'h00}, 1'b0, '0},
      '{{OP_WRITE_AT, 8'hAA, COL_LAST, ROW_LAST, 8'h55}, 1'b0, '0},
      '{{OP_READ, 8'h00, COL_LAST, ROW_LAST, 8'h00}, 1'b0, '0},
      '{{OP_SPARE_A, 8'hFF, COL_MAX, ROW_MAX, 8'hFF}, 1'b0, '0},
      '{{OP_SPARE_B, 8'h55, 7'd0, 5'd0, 8'hAA}, 1'b0, '0},
      '{{OP_SPARE_C, 8'hAA, 7'd85, 5'd21, 8'h55}, 1'b0, '0},
      '{{OP_WRITE_AT, 8'h00, 7'd0, 5'd0, 8'h00}, 1'b0, '0},
      '{{OP_READ, 8'h00, COL_MAX, ROW_MAX, 8'h00}, 1'b0, '0},
      '{{OP_READ, 8'h00, 7'd0, 5'd0, 8'h00}, 1'b0, '0}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      case (phase)
        0:       attr = '0;
        1:       attr = '1;
        default: attr = ATTR_W'($urandom_range(0, 255));
      endcase
      write_default_attr(attr);
      // one phase runs with no idling at all, one with a sink that never stalls
      max_gap   = (phase == 2) ? 0 : 3;
      max_stall = (phase == 2 || phase == 3) ? 0 : 3;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 59) == 0) begin
          // long run of puts: can wrap lines and scroll from the bottom row
          burst_len = $urandom_range(20, 90);
          repeat (burst_len) begin
            it = random_console_item();
            it.op = OP_PUT;
            if (it.char_code == NEWLINE_CODE) it.char_code = SPACE_CODE;
            send_item(it, 1'b0, '0);
            sent++;
          end
        end else begin
          send_item(random_console_item(), 1'b0, '0);
          sent++;
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/cons_pkg.sv
hw/rtl/cons_in_if.sv
hw/rtl/cons_out_if.sv
hw/rtl/cons_addr.sv
hw/rtl/cons_store.sv
hw/rtl/cons_ctrl.sv
hw/rtl/text_console_cursor_scroll.sv
dv/tb_text_console_cursor_scroll.sv
